// File: hw/rtl/amf0_pkg.sv
package amf0_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int LVL_W     = 4;
  localparam int IDX_W     = 3;

  // Parser phases
  localparam logic [4:0] PH_MARKER = 5'd0;
  localparam logic [4:0] PH_NUM    = 5'd1;
  localparam logic [4:0] PH_BOOL   = 5'd2;
  localparam logic [4:0] PH_REF    = 5'd3;
  localparam logic [4:0] PH_DATE   = 5'd4;
  localparam logic [4:0] PH_SLEN   = 5'd5;
  localparam logic [4:0] PH_LLEN   = 5'd6;
  localparam logic [4:0] PH_XLEN   = 5'd7;
  localparam logic [4:0] PH_STEXT  = 5'd8;
  localparam logic [4:0] PH_LTEXT  = 5'd9;
  localparam logic [4:0] PH_XTEXT  = 5'd10;
  localparam logic [4:0] PH_ECOUNT = 5'd11;
  localparam logic [4:0] PH_ACOUNT = 5'd12;
  localparam logic [4:0] PH_PLEN   = 5'd13;
  localparam logic [4:0] PH_PEMPTY = 5'd14;
  localparam logic [4:0] PH_NTEXT  = 5'd15;

  // Events
  localparam logic [2:0] EV_CONSUMED = 3'd0;
  localparam logic [2:0] EV_SCALAR   = 3'd1;
  localparam logic [2:0] EV_OPEN     = 3'd2;
  localparam logic [2:0] EV_CLOSE    = 3'd3;
  localparam logic [2:0] EV_NAME     = 3'd4;
  localparam logic [2:0] EV_MSG_OK   = 3'd5;
  localparam logic [2:0] EV_ERROR    = 3'd6;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNC     = 3'd1;
  localparam logic [2:0] ERR_UTF8      = 3'd2;
  localparam logic [2:0] ERR_UNSUPP    = 3'd3;
  localparam logic [2:0] ERR_DEEP      = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd5;

  // Markers
  localparam logic [7:0] MK_NUMBER  = 8'h00;
  localparam logic [7:0] MK_BOOL    = 8'h01;
  localparam logic [7:0] MK_STRING  = 8'h02;
  localparam logic [7:0] MK_OBJECT  = 8'h03;
  localparam logic [7:0] MK_CLIP    = 8'h04;
  localparam logic [7:0] MK_NULL    = 8'h05;
  localparam logic [7:0] MK_UNDEF   = 8'h06;
  localparam logic [7:0] MK_REF     = 8'h07;
  localparam logic [7:0] MK_ECMA    = 8'h08;
  localparam logic [7:0] MK_OBJEND  = 8'h09;
  localparam logic [7:0] MK_STRICT  = 8'h0a;
  localparam logic [7:0] MK_DATE    = 8'h0b;
  localparam logic [7:0] MK_LSTRING = 8'h0c;
  localparam logic [7:0] MK_UNSUPP  = 8'h0d;
  localparam logic [7:0] MK_RECSET  = 8'h0e;
  localparam logic [7:0] MK_XML     = 8'h0f;
  localparam logic [7:0] MK_TYPED   = 8'h10;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [4:0]  value_kind;
    logic [3:0]  depth;
    logic [63:0] payload;
    logic        is_text_byte;
    logic [2:0]  error_code;
    logic        last;
  } res_t;

  // Marker reported for a byte inside a value body
  function automatic logic [4:0] phase_kind(input logic [4:0] ph);
    logic [4:0] k;
    unique case (ph)
      PH_NUM:    k = 5'd0;
      PH_BOOL:   k = 5'd1;
      PH_REF:    k = 5'd7;
      PH_DATE:   k = 5'd11;
      PH_SLEN, PH_STEXT, PH_PLEN, PH_PEMPTY, PH_NTEXT: k = 5'd2;
      PH_LLEN, PH_LTEXT:   k = 5'd12;
      PH_XLEN, PH_XTEXT:   k = 5'd15;
      PH_ECOUNT: k = 5'd8;
      PH_ACOUNT: k = 5'd10;
      default:   k = 5'd0;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/amf0_msg_if.sv
interface amf0_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// File: hw/rtl/amf0_evt_if.sv
interface amf0_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [4:0]  value_kind;
  logic [3:0]  depth;
  logic [63:0] payload;
  logic        is_text_byte;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output event_res, output value_kind, output depth,
                  output payload, output is_text_byte, output error_code, output last,
                  input ready);
  modport sink   (input valid, input event_res, input value_kind, input depth,
                  input payload, input is_text_byte, input error_code, input last,
                  output ready);
endinterface

// File: hw/rtl/amf0_parse_core.sv
module amf0_parse_core
  import amf0_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic [3:0] depth_limit,
  output res_t       res
);

  // Parse state
  logic [4:0]        phase, phase_next;
  logic [3:0]        hdr, hdr_next;
  logic [63:0]       acc, acc_next;
  logic [31:0]       chars, chars_next;
  logic [1:0]        cont, cont_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic              err_seen, err_seen_next;

  // Container stack: kind flags and strict-array counts per level
  logic [MAX_DEPTH-1:0] is_strict, is_ecma, cnt_one;
  logic [31:0]          cnt_mem [MAX_DEPTH];

  logic              st_we;
  logic [IDX_W-1:0]  st_idx;
  logic              st_strict, st_ecma;
  logic [31:0]       st_cnt;

  // Shared finish logic
  logic [63:0]       acc_sh;
  logic              pop1;
  logic [LVL_W-1:0]  fin_start, fin_lvl;
  logic              fin_closed, fin_still, fin_plen, fin_dec;
  logic [IDX_W-1:0]  fin_idx;
  logic [31:0]       fin_cnt;

  assign acc_sh = {acc[55:0], data_byte};
  assign pop1 = !err_seen && (lvl != '0) &&
                (((phase == PH_PEMPTY) && (data_byte == MK_OBJEND)) ||
                 ((phase == PH_ACOUNT) && (hdr <= 4'd1) && (acc_sh[31:0] == 32'd0)));
  assign fin_start = pop1 ? lvl - 1'b1 : lvl;

  // Pop strict arrays whose last element just completed
  always_comb begin
    fin_lvl   = fin_start;
    fin_still = 1'b1;
    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
      if (LVL_W'(i) < fin_start && fin_still) begin
        if (is_strict[i] && cnt_one[i]) fin_lvl = LVL_W'(i);
        else fin_still = 1'b0;
      end
    end
    fin_closed = fin_lvl != fin_start;
    fin_idx    = IDX_W'(fin_lvl - 1'b1);
    fin_plen   = (fin_lvl != '0) && !is_strict[fin_idx];
    fin_dec    = (fin_lvl != '0) && is_strict[fin_idx];
    fin_cnt    = cnt_mem[fin_idx] - 32'd1;
  end

  always_comb begin
    logic [4:0]  kind;
    logic [2:0]  ev;
    logic [2:0]  err;
    logic [63:0] pay;
    logic        text;
    logic        finish;
    logic        open_c;
    logic        op_strict, op_ecma;
    logic [4:0]  op_phase;
    logic [3:0]  op_hdr;
    logic [3:0]  limit;
    logic [3:0]  hdr_d;
    logic [1:0]  ulen;
    logic        bad;
    logic [31:0] len;
    logic [LVL_W-1:0] depth_out;

    phase_next    = phase;
    hdr_next      = hdr;
    acc_next      = acc;
    chars_next    = chars;
    cont_next     = cont;
    lvl_next      = lvl;
    err_seen_next = err_seen;
    st_we     = 1'b0;
    st_idx    = IDX_W'(lvl);
    st_strict = 1'b0;
    st_ecma   = 1'b0;
    st_cnt    = 32'd0;

    ev     = EV_CONSUMED;
    err    = ERR_NONE;
    pay    = 64'd0;
    kind   = phase_kind(phase);
    text   = (phase == PH_STEXT) || (phase == PH_LTEXT) ||
             (phase == PH_XTEXT) || (phase == PH_NTEXT);
    finish = 1'b0;
    open_c = 1'b0;
    op_strict = 1'b0;
    op_ecma   = 1'b0;
    op_phase  = PH_PLEN;
    op_hdr    = 4'd2;
    limit  = (depth_limit < 4'(MAX_DEPTH)) ? depth_limit : 4'(MAX_DEPTH);
    hdr_d  = 4'd0;
    ulen   = 2'd0;
    bad    = 1'b0;
    len    = 32'd0;

    if (err_seen) begin
      // Drain the rest of a failed message
      kind = 5'd0;
      text = 1'b0;
      depth_out = lvl;
      if (end_of_message) begin
        ev = EV_ERROR;
        depth_out = '0;
        phase_next = PH_MARKER; hdr_next = '0; acc_next = '0; chars_next = '0;
        cont_next = '0; lvl_next = '0; err_seen_next = 1'b0;
      end
    end else begin
      if ((phase == PH_MARKER) || ((phase == PH_PEMPTY) && !pop1)) begin
        // Decode a value marker
        kind = (data_byte <= MK_TYPED) ? data_byte[4:0] : 5'd0;
        unique case (data_byte)
          MK_NUMBER:  begin phase_next = PH_NUM;   hdr_next = 4'd8;  acc_next = '0; end
          MK_BOOL:    begin phase_next = PH_BOOL;  hdr_next = 4'd1;  acc_next = '0; end
          MK_STRING:  begin phase_next = PH_SLEN;  hdr_next = 4'd2;  acc_next = '0; end
          MK_REF:     begin phase_next = PH_REF;   hdr_next = 4'd2;  acc_next = '0; end
          MK_DATE:    begin phase_next = PH_DATE;  hdr_next = 4'd10; acc_next = '0; end
          MK_LSTRING: begin phase_next = PH_LLEN;  hdr_next = 4'd4;  acc_next = '0; end
          MK_XML:     begin phase_next = PH_XLEN;  hdr_next = 4'd4;  acc_next = '0; end
          MK_NULL, MK_UNDEF: begin finish = 1'b1; pay = 64'd0; end
          MK_OBJECT:  begin open_c = 1'b1; op_phase = PH_PLEN; op_hdr = 4'd2; end
          MK_ECMA:    begin
            open_c = 1'b1; op_ecma = 1'b1; op_phase = PH_ECOUNT; op_hdr = 4'd4;
          end
          MK_STRICT:  begin
            open_c = 1'b1; op_strict = 1'b1; op_phase = PH_ACOUNT; op_hdr = 4'd4;
          end
          MK_CLIP, MK_OBJEND, MK_UNSUPP, MK_RECSET, MK_TYPED: begin
            ev = EV_ERROR; err = ERR_UNSUPP;
          end
          default: begin ev = EV_ERROR; err = ERR_UNKNOWN; end
        endcase
        if (open_c) begin
          if ((lvl >= limit) || (lvl >= LVL_W'(MAX_DEPTH))) begin
            ev = EV_ERROR; err = ERR_DEEP;
          end else begin
            st_we = 1'b1; st_idx = IDX_W'(lvl);
            st_strict = op_strict; st_ecma = op_ecma; st_cnt = 32'd0;
            lvl_next = lvl + 1'b1;
            phase_next = op_phase; hdr_next = op_hdr; acc_next = '0;
            ev = EV_OPEN;
          end
        end
      end else if (phase == PH_PEMPTY) begin
        // Object end after an empty name
        finish = 1'b1;
        kind = is_strict[IDX_W'(lvl - 1'b1)] ? 5'd10 :
               (is_ecma[IDX_W'(lvl - 1'b1)] ? 5'd8 : 5'd3);
        ev = EV_CLOSE;
      end else if (text) begin
        // Count characters by UTF-8 lead byte
        if (cont != 2'd0) begin
          cont_next = cont - 2'd1;
          chars_next = chars;
        end else begin
          if (data_byte <= 8'h7f) ulen = 2'd0;
          else if ((data_byte >= 8'hc2) && (data_byte <= 8'hdf)) ulen = 2'd1;
          else if ((data_byte >= 8'he0) && (data_byte <= 8'hef)) ulen = 2'd2;
          else if ((data_byte >= 8'hf0) && (data_byte <= 8'hf4)) ulen = 2'd3;
          else bad = 1'b1;
          chars_next = chars - 32'd1;
          cont_next  = ulen;
        end
        if (bad) begin
          chars_next = chars; cont_next = cont;
          ev = EV_ERROR; err = ERR_UTF8;
        end else begin
          acc_next = acc + 64'd1;
          if ((chars_next == 32'd0) && (cont_next == 2'd0)) begin
            if (phase == PH_NTEXT) begin
              ev = EV_NAME; pay = acc_next;
              phase_next = PH_MARKER; hdr_next = '0; acc_next = '0;
            end else begin
              finish = 1'b1; pay = acc + 64'd1;
            end
          end
        end
      end else begin
        // Header and fixed-size body bytes
        if ((phase != PH_DATE) || (hdr > 4'd2)) acc_next = acc_sh;
        hdr_d = (hdr != 4'd0) ? hdr - 4'd1 : 4'd0;
        hdr_next = hdr_d;
        if (hdr_d == 4'd0) begin
          unique case (phase)
            PH_NUM, PH_BOOL, PH_REF, PH_DATE: begin
              finish = 1'b1; pay = acc_next;
            end
            PH_SLEN, PH_LLEN, PH_XLEN: begin
              len = (phase == PH_SLEN) ? {16'd0, acc_next[15:0]} : acc_next[31:0];
              if (len == 32'd0) begin
                finish = 1'b1; pay = 64'd0;
              end else begin
                chars_next = len; cont_next = '0; acc_next = '0;
                phase_next = (phase == PH_SLEN) ? PH_STEXT :
                             ((phase == PH_LLEN) ? PH_LTEXT : PH_XTEXT);
              end
            end
            PH_ECOUNT: begin phase_next = PH_PLEN; hdr_next = 4'd2; acc_next = '0; end
            PH_ACOUNT: begin
              len = acc_next[31:0];
              if (lvl == '0) begin
                phase_next = PH_MARKER; hdr_next = '0; acc_next = '0;
              end else if (len == 32'd0) begin
                finish = 1'b1; ev = EV_CLOSE; kind = 5'd10;
              end else begin
                st_we = 1'b1; st_idx = IDX_W'(lvl - 1'b1);
                st_strict = 1'b1; st_ecma = 1'b0; st_cnt = len;
                phase_next = PH_MARKER; hdr_next = '0; acc_next = '0;
              end
            end
            PH_PLEN: begin
              len = {16'd0, acc_next[15:0]};
              if (len == 32'd0) begin
                phase_next = PH_PEMPTY; hdr_next = '0; acc_next = '0;
              end else begin
                chars_next = len; cont_next = '0; acc_next = '0; phase_next = PH_NTEXT;
              end
            end
            default: begin phase_next = PH_MARKER; hdr_next = '0; acc_next = '0; end
          endcase
        end
      end

      // Return to the enclosing container
      if (finish) begin
        acc_next = '0;
        hdr_next = fin_plen ? 4'd2 : 4'd0;
        phase_next = fin_plen ? PH_PLEN : PH_MARKER;
        lvl_next = fin_lvl;
        if (fin_dec && !fin_closed) begin
          // count not exhausted: write back decremented count
          st_we = 1'b1; st_idx = fin_idx;
          st_strict = 1'b1; st_ecma = 1'b0; st_cnt = fin_cnt;
        end else if (fin_dec) begin
          st_we = 1'b1; st_idx = fin_idx;
          st_strict = 1'b1; st_ecma = 1'b0; st_cnt = fin_cnt;
        end
        if (ev != EV_CLOSE) ev = fin_closed ? EV_CLOSE : EV_SCALAR;
        if (fin_closed) kind = 5'd10;
      end

      depth_out = lvl_next;
      if (ev == EV_ERROR) begin
        pay = 64'd0;
        if (end_of_message) begin
          phase_next = PH_MARKER; hdr_next = '0; acc_next = '0; chars_next = '0;
          cont_next = '0; lvl_next = '0; err_seen_next = 1'b0;
        end else begin
          err_seen_next = 1'b1;
        end
      end else if (end_of_message) begin
        if ((lvl_next == '0) && (phase_next == PH_MARKER)) begin
          ev = EV_MSG_OK;
        end else begin
          ev = EV_ERROR; err = ERR_TRUNC; pay = 64'd0;
        end
        phase_next = PH_MARKER; hdr_next = '0; acc_next = '0; chars_next = '0;
        cont_next = '0; lvl_next = '0; err_seen_next = 1'b0;
      end
    end

    res.event_res    = ev;
    res.value_kind   = kind;
    res.depth        = depth_out;
    res.payload      = pay;
    res.is_text_byte = text;
    res.error_code   = err;
    res.last         = end_of_message;
  end

  // Hold or advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MARKER;
      hdr      <= '0;
      acc      <= '0;
      chars    <= '0;
      cont     <= '0;
      lvl      <= '0;
      err_seen <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      hdr      <= hdr_next;
      acc      <= acc_next;
      chars    <= chars_next;
      cont     <= cont_next;
      lvl      <= lvl_next;
      err_seen <= err_seen_next;
    end
  end

  // Write one stack entry
  always_ff @(posedge clk) begin
    if (step && st_we) begin
      is_strict[st_idx] <= st_strict;
      is_ecma[st_idx]   <= st_ecma;
      cnt_one[st_idx]   <= st_cnt == 32'd1;
      cnt_mem[st_idx]   <= st_cnt;
    end
  end

endmodule

// File: hw/rtl/amf0_stream_parser.sv
// AMF0 stream parser.
// msg: one AMF0 message byte per item (data_byte, end_of_message), valid/ready.
// evt: one event item per accepted byte, in order, valid/ready. cfg_we/cfg_data
// write depth_limit (reset 8). Write only while the block is idle, unenforced.
// An accepted byte lands in an input register; the parse logic runs from that
// register and the state and loads the event register when that one is free or
// being taken.
// Throughput is one byte per cycle unless evt stalls: the parse state updates
// once per byte; the input register refills in the same cycle the event loads.
// When evt stalls, the event register holds, one more byte may wait in the
// input register, and then msg.ready drops until the event is taken.
// Reset (rst, synchronous) empties both registers, returns the parser to
// expecting a marker at depth 0 and sets depth_limit to 8.
// Every final byte resets the parse state, with a message-ok or error event.
module amf0_stream_parser
  import amf0_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  amf0_msg_if.sink   msg,
  amf0_evt_if.source evt,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  logic       in_v;
  logic [7:0] in_byte;
  logic       in_eom;
  logic       adv;
  logic [3:0] depth_limit;
  res_t       res, out_res;
  logic       out_v;

  assign adv       = in_v && (!out_v || evt.ready);
  assign msg.ready = !in_v || adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 4'd8;
    end else if (cfg_we) begin
      depth_limit <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      in_byte <= msg.data_byte;
      in_eom  <= msg.end_of_message;
    end
  end

  amf0_parse_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (adv),
    .data_byte      (in_byte),
    .end_of_message (in_eom),
    .depth_limit    (depth_limit),
    .res            (res)
  );

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= 1'b1;
    end else if (evt.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign evt.valid        = out_v;
  assign evt.event_res    = out_res.event_res;
  assign evt.value_kind   = out_res.value_kind;
  assign evt.depth        = out_res.depth;
  assign evt.payload      = out_res.payload;
  assign evt.is_text_byte = out_res.is_text_byte;
  assign evt.error_code   = out_res.error_code;
  assign evt.last         = out_res.last;

`ifndef ASSERT_OFF
  a_err_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    out_v && (out_res.error_code != ERR_NONE) |-> out_res.event_res == EV_ERROR)
    else $error("error code without error event");

  a_depth_bounded: assert property (@(posedge clk) disable iff (rst)
    out_v |-> out_res.depth <= 4'(MAX_DEPTH))
    else $error("depth beyond stack size");

  a_ok_at_top: assert property (@(posedge clk) disable iff (rst)
    out_v && (out_res.event_res == EV_MSG_OK) |-> out_res.last && (out_res.depth == 4'd0))
    else $error("message ok inside a container");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_v && out_v && !evt.ready |=> in_v && out_v)
    else $error("item lost while stalled");
`endif

endmodule
